// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers for the latency histogram unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/lhp_pkg.sv =====
`default_nettype none

package lhp_pkg;

  localparam int DATA_W    = 64;
  localparam int PCT_W     = 7;
  localparam int NUM_PCT   = 3;
  localparam int CFG_IDX_W = 2;
  // count * pct fits in 71 bits for pct <= 100, and so does 100 * cum
  localparam int PROD_W    = 71;
  localparam int TOP_BIT   = 63;
  localparam int BIT_IDX_W = 7;

  localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_REPORT = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCT_FIRST  = 2'd0,
    CFG_PCT_SECOND = 2'd1,
    CFG_PCT_THIRD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_MUL,
    ST_WALK,
    ST_DRAIN,
    ST_FLUSH,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic     rec_rd;
    logic     rec_wr;
    logic     rep_start;
    logic     mul_load;
    logic     walk_rd;
    logic     out_load;
    cfg_idx_e sel;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lhp_if.sv =====
`default_nettype none

interface lhp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [lhp_pkg::DATA_W-1:0]  latency_ns;

  modport source (output valid, output action, output latency_ns, input ready);
  modport sink   (input valid, input action, input latency_ns, output ready);
endinterface

interface lhp_out_if;
  logic                        valid;
  logic                        ready;
  logic [lhp_pkg::DATA_W-1:0]  sample_total;
  logic [lhp_pkg::DATA_W-1:0]  latency_total;
  logic [lhp_pkg::DATA_W-1:0]  latency_peak;
  logic [lhp_pkg::DATA_W-1:0]  pctl_first_ns;
  logic [lhp_pkg::DATA_W-1:0]  pctl_second_ns;
  logic [lhp_pkg::DATA_W-1:0]  pctl_third_ns;

  modport source (output valid, output sample_total, output latency_total,
                  output latency_peak, output pctl_first_ns, output pctl_second_ns,
                  output pctl_third_ns, input ready);
  modport sink   (input valid, input sample_total, input latency_total,
                  input latency_peak, input pctl_first_ns, input pctl_second_ns,
                  input pctl_third_ns, output ready);
endinterface

`default_nettype wire

// ===== rtl/log2_latency_histogram_percentiles_unit.sv =====
// Record item: bucket read, then increment write; the next item is taken right after.
// Report item, from transfer to result valid: three threshold products, a walk of one
// bucket per cycle, drain and flush states, and a load that waits while the output is full.
// The result sits in an output register; records are taken while it waits.
// Reset (async, active low) clears counters, sum, maximum and bucket valid bits,
// and sets the percentiles to 50, 95 and 99.
`default_nettype none

`include "assert_macros.svh"

module log2_latency_histogram_percentiles_unit #(
  parameter int NUM_BUCKETS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lhp_in_if.sink                             in_i,
  lhp_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lhp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lhp_pkg::PCT_W-1:0]     cfg_data_i
);

  localparam int BW = $clog2(NUM_BUCKETS);

  lhp_pkg::cmd_t    cmd;
  lhp_pkg::status_t status;
  logic [BW-1:0]    walk_addr;
  logic             rec_xfer;
  logic [4:0]       dp_cmds;

  lhp_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .walk_addr_o (walk_addr)
  );

  lhp_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .walk_addr_i     (walk_addr),
    .latency_i       (in_i.latency_ns),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .sample_total_o  (out_o.sample_total),
    .latency_total_o (out_o.latency_total),
    .latency_peak_o  (out_o.latency_peak),
    .pctl_first_o    (out_o.pctl_first_ns),
    .pctl_second_o   (out_o.pctl_second_ns),
    .pctl_third_o    (out_o.pctl_third_ns)
  );

  assign rec_xfer = in_i.valid && in_i.ready && (in_i.action == lhp_pkg::ACT_RECORD);
  assign dp_cmds  = {cmd.rec_rd, cmd.rec_wr, cmd.mul_load, cmd.walk_rd, cmd.out_load};

  `ASSERT_PROP(a_rec_write_follows, clk_i, rst_ni, rec_xfer |=> cmd.rec_wr, "no bucket write")
  `ASSERT_PROP(a_cmd_exclusive, clk_i, rst_ni, $onehot0(dp_cmds), "conflicting commands")
  `ASSERT_PROP(a_out_no_overwrite, clk_i, rst_ni, cmd.out_load |-> (!status.out_full || out_o.ready), "result overwritten")
  `ASSERT_NEVER(a_no_accept_in_walk, clk_i, rst_ni, in_i.ready && cmd.walk_rd, "ready during walk")

endmodule

`default_nettype wire

// ===== rtl/lhp_ctrl.sv =====
`default_nettype none

module lhp_ctrl #(
  parameter int NUM_BUCKETS = 32,
  parameter int BW          = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_action_i,
  output      logic             in_ready_o,
  input  wire logic             out_ready_i,
  input  wire lhp_pkg::status_t status_i,
  output      lhp_pkg::cmd_t    cmd_o,
  output      logic [BW-1:0]    walk_addr_o
);

  lhp_pkg::ctrl_state_e state_q, state_d;
  lhp_pkg::cfg_idx_e    k_q, k_d;
  logic [BW-1:0]        addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhp_pkg::ST_IDLE;
      k_q     <= lhp_pkg::CFG_PCT_FIRST;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    addr_d     = addr_q;
    cmd_o      = '0;
    cmd_o.sel  = k_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      lhp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == lhp_pkg::ACT_RECORD) begin
            cmd_o.rec_rd = 1'b1;
            state_d      = lhp_pkg::ST_REC;
          end else begin
            cmd_o.rep_start = 1'b1;
            k_d             = lhp_pkg::CFG_PCT_FIRST;
            state_d         = lhp_pkg::ST_MUL;
          end
        end
      end
      lhp_pkg::ST_REC: begin
        cmd_o.rec_wr = 1'b1;
        state_d      = lhp_pkg::ST_IDLE;
      end
      lhp_pkg::ST_MUL: begin
        // one threshold product per cycle, first to third percentile
        cmd_o.mul_load = 1'b1;
        if (k_q == lhp_pkg::CFG_PCT_THIRD) begin
          addr_d  = '0;
          state_d = lhp_pkg::ST_WALK;
        end else begin
          k_d = lhp_pkg::cfg_idx_e'(k_q + 2'd1);
        end
      end
      lhp_pkg::ST_WALK: begin
        cmd_o.walk_rd = 1'b1;
        if (addr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = lhp_pkg::ST_DRAIN;
        end else begin
          addr_d = addr_q + BW'(1);
        end
      end
      lhp_pkg::ST_DRAIN: begin
        state_d = lhp_pkg::ST_FLUSH;
      end
      lhp_pkg::ST_FLUSH: begin
        state_d = lhp_pkg::ST_DONE;
      end
      lhp_pkg::ST_DONE: begin
        // hold the finished report until the output register frees up
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lhp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lhp_pkg::ST_IDLE;
      end
    endcase
  end

  assign walk_addr_o = addr_q;

endmodule

`default_nettype wire

// ===== rtl/lhp_dp.sv =====
`default_nettype none

module lhp_dp #(
  parameter int NUM_BUCKETS = 32,
  parameter int BW          = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lhp_pkg::cmd_t                     cmd_i,
  output      lhp_pkg::status_t                  status_o,
  input  wire logic [BW-1:0]                     walk_addr_i,
  input  wire logic [lhp_pkg::DATA_W-1:0]        latency_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lhp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lhp_pkg::PCT_W-1:0]         cfg_data_i,
  input  wire logic                              out_ready_i,
  output      logic                              out_valid_o,
  output      logic [lhp_pkg::DATA_W-1:0]        sample_total_o,
  output      logic [lhp_pkg::DATA_W-1:0]        latency_total_o,
  output      logic [lhp_pkg::DATA_W-1:0]        latency_peak_o,
  output      logic [lhp_pkg::DATA_W-1:0]        pctl_first_o,
  output      logic [lhp_pkg::DATA_W-1:0]        pctl_second_o,
  output      logic [lhp_pkg::DATA_W-1:0]        pctl_third_o
);

  localparam int DW = lhp_pkg::DATA_W;
  localparam int NP = lhp_pkg::NUM_PCT;
  localparam int PW = lhp_pkg::PROD_W;

  // configuration
  logic [lhp_pkg::PCT_W-1:0] pct_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q[0] <= 7'd50;
      pct_q[1] <= 7'd95;
      pct_q[2] <= 7'd99;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lhp_pkg::CFG_PCT_FIRST:  pct_q[0] <= cfg_data_i;
        lhp_pkg::CFG_PCT_SECOND: pct_q[1] <= cfg_data_i;
        lhp_pkg::CFG_PCT_THIRD:  pct_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bucket index of the incoming sample: position of the leading one, clamped to the last bucket
  logic [lhp_pkg::BIT_IDX_W-1:0] top_bit;
  logic [BW-1:0]                 bidx;

  always_comb begin
    top_bit = '0;
    for (int i = 1; i <= lhp_pkg::TOP_BIT; i++) begin
      if (latency_i[i]) top_bit = lhp_pkg::BIT_IDX_W'(i);
    end
    if (top_bit > lhp_pkg::BIT_IDX_W'(NUM_BUCKETS - 1)) begin
      bidx = BW'(NUM_BUCKETS - 1);
    end else begin
      bidx = top_bit[BW-1:0];
    end
  end

  // bucket memory, entries read as zero until first written
  logic [DW-1:0]          bkt_mem_q [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] bvld_q;
  logic [BW-1:0]          rd_addr;
  logic [DW-1:0]          rdata_q;
  logic                   rd_vld_q;
  logic [DW-1:0]          rdata_eff;
  logic [BW-1:0]          ridx_q;
  logic [DW-1:0]          lat_q;

  assign rd_addr   = cmd_i.rec_rd ? bidx : walk_addr_i;
  assign rdata_eff = rd_vld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    rdata_q <= bkt_mem_q[rd_addr];
    if (cmd_i.rec_wr) begin
      bkt_mem_q[ridx_q] <= rdata_eff + DW'(1);
    end
    if (cmd_i.rec_rd) begin
      lat_q  <= latency_i;
      ridx_q <= bidx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= bvld_q[rd_addr];
      if (cmd_i.rec_wr) bvld_q[ridx_q] <= 1'b1;
    end
  end

  // running statistics
  logic [DW-1:0] cnt_q, sum_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      max_q <= '0;
    end else if (cmd_i.rec_wr) begin
      cnt_q <= cnt_q + DW'(1);
      sum_q <= sum_q + lat_q;
      if (lat_q > max_q) max_q <= lat_q;
    end
  end

  // threshold count * pct per percentile; cum >= ceil(count * pct / 100)
  // holds exactly when 100 * cum >= count * pct
  logic [lhp_pkg::PCT_W-1:0] pct_raw, pct_sel;
  logic [PW-1:0]             prod_q [NP];

  always_comb begin
    case (cmd_i.sel)
      lhp_pkg::CFG_PCT_FIRST:  pct_raw = pct_q[0];
      lhp_pkg::CFG_PCT_SECOND: pct_raw = pct_q[1];
      default:                 pct_raw = pct_q[2];
    endcase
    pct_sel = (pct_raw > lhp_pkg::PCT_MAX) ? lhp_pkg::PCT_MAX : pct_raw;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q[cmd_i.sel] <= PW'(cnt_q) * PW'(pct_sel);
    end
  end

  // cumulative walk over the buckets: accumulate, then check the registered total in the next cycle
  logic          walk_q;
  logic          chk_q;
  logic [BW-1:0] widx_q;
  logic [BW-1:0] cidx_q;
  logic [DW-1:0] cum_q;
  logic [DW:0]   cum_sum;
  logic [DW-1:0] cum_next;
  logic [PW-1:0] cum_x100;
  logic [NP-1:0] reach;
  logic [DW-1:0] ub;
  logic [DW-1:0] ub_cap;
  logic [NP-1:0] hit_q;
  logic [DW-1:0] est_q [NP];

  always_comb begin
    cum_sum  = {1'b0, cum_q} + {1'b0, rdata_eff};
    cum_next = cum_sum[DW] ? '1 : cum_sum[DW-1:0];
    // 100 * cum as 64 + 32 + 4 times cum
    cum_x100 = (PW'(cum_q) << 6) + (PW'(cum_q) << 5) + (PW'(cum_q) << 2);
    // a zero total never reaches the target, which is at least one
    for (int k = 0; k < NP; k++) begin
      reach[k] = (cum_q != '0) && (cum_x100 >= prod_q[k]);
    end
    for (int i = 0; i < DW; i++) begin
      ub[i] = (lhp_pkg::BIT_IDX_W'(i) <= lhp_pkg::BIT_IDX_W'(cidx_q));
    end
    ub_cap = (ub < max_q) ? ub : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= 1'b0;
      chk_q  <= 1'b0;
      hit_q  <= '0;
    end else begin
      walk_q <= cmd_i.walk_rd;
      chk_q  <= walk_q;
      if (cmd_i.rep_start) begin
        hit_q <= '0;
      end else if (chk_q) begin
        for (int k = 0; k < NP; k++) begin
          if (!hit_q[k] && reach[k]) hit_q[k] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q <= walk_addr_i;
    cidx_q <= widx_q;
    if (cmd_i.rep_start) begin
      cum_q <= '0;
    end else if (walk_q) begin
      cum_q <= cum_next;
    end
    if (chk_q) begin
      for (int k = 0; k < NP; k++) begin
        if (!hit_q[k] && reach[k]) est_q[k] <= ub_cap;
      end
    end
  end

  // output register
  logic          out_full_q;
  logic [DW-1:0] o_cnt_q, o_sum_q, o_max_q;
  logic [DW-1:0] o_pct_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_full_q <= 1'b1;
    end else if (out_ready_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_cnt_q <= cnt_q;
      o_sum_q <= sum_q;
      o_max_q <= max_q;
      for (int k = 0; k < NP; k++) begin
        if (cnt_q == '0) begin
          o_pct_q[k] <= '0;
        end else if (hit_q[k]) begin
          o_pct_q[k] <= est_q[k];
        end else begin
          o_pct_q[k] <= max_q;
        end
      end
    end
  end

  assign status_o.out_full = out_full_q;

  assign out_valid_o     = out_full_q;
  assign sample_total_o  = o_cnt_q;
  assign latency_total_o = o_sum_q;
  assign latency_peak_o  = o_max_q;
  assign pctl_first_o    = o_pct_q[0];
  assign pctl_second_o   = o_pct_q[1];
  assign pctl_third_o    = o_pct_q[2];

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_BUCKETS   = 32;
  localparam int SETTLE_CYCLES = NUM_BUCKETS + 260;
  localparam int HOLD_CYCLES   = 1500;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef logic [lhp_pkg::DATA_W-1:0] word_t;
  typedef logic [lhp_pkg::PCT_W-1:0]  pct_t;

  typedef struct {
    word_t count;
    word_t sum;
    word_t peak;
    word_t pctl[lhp_pkg::NUM_PCT];
  } report_t;

  // Tracks the histogram state and holds the reports still owed by the unit.
  class histogram_tracker;
    word_t   bucket_cnt[NUM_BUCKETS];
    word_t   count;
    word_t   sum;
    word_t   peak;
    pct_t    pct[lhp_pkg::NUM_PCT];
    report_t pending_reports[$];
    int      errors;

    function new();
      foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
      count  = '0;
      sum    = '0;
      peak   = '0;
      pct[0] = 7'd50;
      pct[1] = 7'd95;
      pct[2] = 7'd99;
      errors = 0;
    endfunction

    function void set_pct(lhp_pkg::cfg_idx_e idx, pct_t value);
      pct[int'(idx)] = value;
    endfunction

    function int bucket_of(word_t v);
      int top;
      top = 0;
      for (int i = 1; i < lhp_pkg::DATA_W; i++)
        if (v[i]) top = i;
      if (top > NUM_BUCKETS - 1) top = NUM_BUCKETS - 1;
      return top;
    endfunction

    function word_t percentile(pct_t p);
      logic [lhp_pkg::PROD_W-1:0] prod;
      logic [lhp_pkg::PCT_W-1:0]  pc;
      logic [lhp_pkg::DATA_W:0]   nxt;
      word_t                      target;
      word_t                      cum;
      word_t                      ub;
      if (count == '0) return '0;
      pc     = (p > lhp_pkg::PCT_MAX) ? lhp_pkg::PCT_MAX : p;
      prod   = lhp_pkg::PROD_W'(count) * lhp_pkg::PROD_W'(pc) + lhp_pkg::PROD_W'(99);
      target = word_t'(prod / lhp_pkg::PROD_W'(100));
      if (target == '0) target = word_t'(1);
      cum = '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        // saturate the running total instead of wrapping
        nxt = {1'b0, cum} + {1'b0, bucket_cnt[b]};
        cum = nxt[lhp_pkg::DATA_W] ? '1 : nxt[lhp_pkg::DATA_W-1:0];
        if (cum >= target) begin
          ub = (b >= lhp_pkg::TOP_BIT) ? '1 : ((word_t'(1) << (b + 1)) - word_t'(1));
          return (ub < peak) ? ub : peak;
        end
      end
      return peak;
    endfunction

    function void note_item(lhp_pkg::action_e act, word_t lat);
      report_t r;
      if (act == lhp_pkg::ACT_RECORD) begin
        bucket_cnt[bucket_of(lat)] += word_t'(1);
        count += word_t'(1);
        sum   += lat;
        if (lat > peak) peak = lat;
      end else begin
        r.count = count;
        r.sum   = sum;
        r.peak  = peak;
        for (int k = 0; k < lhp_pkg::NUM_PCT; k++) r.pctl[k] = percentile(pct[k]);
        pending_reports.push_back(r);
      end
    endfunction

    function void compare(string field, word_t exp_v, word_t got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none, actual count %h sum %h",
                 $time, got.count, got.sum);
        return;
      end
      exp_r = pending_reports.pop_front();
      compare("sample_total", exp_r.count, got.count);
      compare("latency_total", exp_r.sum, got.sum);
      compare("latency_peak", exp_r.peak, got.peak);
      compare("pctl_first_ns", exp_r.pctl[0], got.pctl[0]);
      compare("pctl_second_ns", exp_r.pctl[1], got.pctl[1]);
      compare("pctl_third_ns", exp_r.pctl[2], got.pctl[2]);
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_idx;
  pct_t cfg_data;

  int src_idle;
  int sink_idle;
  bit sink_hold;

  histogram_tracker hist;

  lhp_in_if  in_ch ();
  lhp_out_if out_ch ();

  log2_latency_histogram_percentiles_unit #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random back-pressure, plus a forced hold while sink_hold is set.
  always @(negedge clk) begin
    out_ch.ready = !sink_hold && ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    report_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        hist.note_item(lhp_pkg::action_e'(in_ch.action), in_ch.latency_ns);
      if (out_ch.valid && out_ch.ready) begin
        got.count   = out_ch.sample_total;
        got.sum     = out_ch.latency_total;
        got.peak    = out_ch.latency_peak;
        got.pctl[0] = out_ch.pctl_first_ns;
        got.pctl[1] = out_ch.pctl_second_ns;
        got.pctl[2] = out_ch.pctl_third_ns;
        hist.check_report(got);
      end
    end
  end

  function automatic word_t random_latency();
    word_t v;
    int    w;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: begin
        // pick a bit width first so every bucket is hit, clamp region included
        w = $urandom_range(1, lhp_pkg::DATA_W);
        v = {$urandom, $urandom};
        v = v >> (lhp_pkg::DATA_W - w);
        v[w-1] = 1'b1;
      end
    endcase
    return v;
  endfunction

  task automatic send_item(lhp_pkg::action_e act, word_t lat);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid      = 1'b0;
      in_ch.action     = 1'($urandom_range(1));
      in_ch.latency_ns = {$urandom, $urandom};
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.action     = act;
    in_ch.latency_ns = lat;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_traffic(int n, int report_pct);
    lhp_pkg::action_e act;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(99) < report_pct) ? lhp_pkg::ACT_REPORT : lhp_pkg::ACT_RECORD;
      send_item(act, random_latency());
    end
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (hist.pending() != 0) @(posedge clk);
  endtask

  // Registers change only with the unit idle: drain, then let any record finish.
  task automatic write_pcts(pct_t first, pct_t second, pct_t third);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1; cfg_idx = lhp_pkg::CFG_PCT_FIRST; cfg_data = first;
    hist.set_pct(lhp_pkg::CFG_PCT_FIRST, first);
    @(negedge clk);
    cfg_idx = lhp_pkg::CFG_PCT_SECOND; cfg_data = second;
    hist.set_pct(lhp_pkg::CFG_PCT_SECOND, second);
    @(negedge clk);
    cfg_idx = lhp_pkg::CFG_PCT_THIRD; cfg_data = third;
    hist.set_pct(lhp_pkg::CFG_PCT_THIRD, third);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    hist             = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = lhp_pkg::CFG_PCT_FIRST;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = lhp_pkg::ACT_RECORD;
    in_ch.latency_ns = '0;
    src_idle         = 0;
    sink_idle        = 0;
    sink_hold        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty report, bucket edges, clamp, sum wrap, reset percentiles.
    send_item(lhp_pkg::ACT_REPORT, '1);
    send_item(lhp_pkg::ACT_RECORD, '0);
    send_item(lhp_pkg::ACT_REPORT, '0);
    send_item(lhp_pkg::ACT_RECORD, 64'd1);
    send_item(lhp_pkg::ACT_RECORD, 64'd2);
    send_item(lhp_pkg::ACT_RECORD, 64'd3);
    send_item(lhp_pkg::ACT_RECORD, 64'h0000_0000_7FFF_FFFF);
    send_item(lhp_pkg::ACT_RECORD, 64'h0000_0000_8000_0000);
    send_item(lhp_pkg::ACT_REPORT, '0);
    send_item(lhp_pkg::ACT_RECORD, 64'h0000_0001_0000_0000);
    send_item(lhp_pkg::ACT_RECORD, 64'h8000_0000_0000_0000);
    send_item(lhp_pkg::ACT_RECORD, '1);
    send_item(lhp_pkg::ACT_REPORT, '0);
    send_item(lhp_pkg::ACT_RECORD, 64'd5);
    send_item(lhp_pkg::ACT_RECORD, 64'd7);
    send_item(lhp_pkg::ACT_REPORT, 64'h5555_5555_5555_5555);

    write_pcts(7'd0, lhp_pkg::PCT_MAX, 7'd127);
    send_item(lhp_pkg::ACT_REPORT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(lhp_pkg::ACT_RECORD, 64'd0);
    send_item(lhp_pkg::ACT_REPORT, '0);

    src_idle  = 7;
    sink_idle = 68;
    run_traffic(300, 10);

    write_pcts(lhp_pkg::PCT_MAX, 7'd1, 7'd0);
    src_idle  = 68;
    sink_idle = 7;
    run_traffic(150, 10);
    // pause the sender until every pending report is out
    drain_reports();
    run_traffic(150, 10);

    write_pcts(pct_t'($urandom_range(127)), pct_t'($urandom_range(lhp_pkg::PCT_MAX)),
               pct_t'($urandom_range(127)));
    src_idle  = 0;
    sink_idle = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end
      run_traffic(60, 35);
    join
    run_traffic(260, 10);

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hist.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
